/* design/char_display_serial_framer_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the character display serial framer
// Labelled concurrent assertions that report through $error.
// ----------------------------------------------------------------------------
`ifndef CHAR_DISPLAY_SERIAL_FRAMER_ASSERT_SVH
`define CHAR_DISPLAY_SERIAL_FRAMER_ASSERT_SVH

// Checked on every edge outside reset.
`define CDSF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define CDSF_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/cdsf_pkg.sv */
// ----------------------------------------------------------------------------
// cdsf_pkg
// Shared types, codes and frame helpers for the character display framer.
// ----------------------------------------------------------------------------
package cdsf_pkg;

  localparam int MAX_COLUMNS_DEF = 32;

  localparam int FUNC_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int FRAME_W = 24;
  localparam int LC_W    = 3;
  localparam int CC_W    = 6;
  localparam int CFG_W   = 6;
  localparam int LINE_W  = 2;

  localparam logic [LC_W-1:0] LINE_COUNT_RST   = 3'd2;
  localparam logic [CC_W-1:0] COLUMN_COUNT_RST = 6'd16;

  localparam logic [BYTE_W-1:0] START_CMD  = 8'hF8;
  localparam logic [BYTE_W-1:0] START_DATA = 8'hFA;
  localparam logic [BYTE_W-1:0] CMD_CLEAR  = 8'h01;

  localparam logic [BYTE_W-1:0] BASE_LINE0 = 8'h80;
  localparam logic [BYTE_W-1:0] BASE_LINE1 = 8'hA0;
  localparam logic [BYTE_W-1:0] BASE_LINE2 = 8'hC0;
  localparam logic [BYTE_W-1:0] BASE_LINE3 = 8'hE0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WRITE_CURSOR = 3'd0,
    FUNC_WRITE_AT     = 3'd1,
    FUNC_SET_CURSOR   = 3'd2,
    FUNC_CLEAR        = 3'd3,
    FUNC_RAW_CMD      = 3'd4,
    FUNC_RAW_DATA     = 3'd5
  } func_t;

  typedef logic [0:0] reg_idx_t;
  localparam reg_idx_t REG_LINE_COUNT   = 1'b0;
  localparam reg_idx_t REG_COLUMN_COUNT = 1'b1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [BYTE_W-1:0] col;
    logic [BYTE_W-1:0] row;
    logic [BYTE_W-1:0] char_code;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               is_data;
    logic               last;
  } frame_t;

  typedef struct packed {
    logic [1:0] count;
    frame_t     first;
    frame_t     second;
  } step_out_t;

  function automatic int col_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  function automatic logic [BYTE_W-1:0] line_base(input logic [LINE_W-1:0] line,
                                                  input logic [LC_W-1:0] lines);
    logic [BYTE_W-1:0] b;
    unique case (line)
      2'd0: b = BASE_LINE0;
      2'd1: b = (lines == 3'd2) ? BASE_LINE2 : BASE_LINE1;
      2'd2: b = BASE_LINE2;
      default: b = BASE_LINE3;
    endcase
    return b;
  endfunction

  // Start byte, then each nibble LSB first followed by four zero fillers.
  function automatic frame_t make_frame(input logic [BYTE_W-1:0] b, input logic data,
                                        input logic last);
    frame_t f;
    f.frame   = {(data ? START_DATA : START_CMD),
                 b[0], b[1], b[2], b[3], 4'b0000,
                 b[4], b[5], b[6], b[7], 4'b0000};
    f.is_data = data;
    f.last    = last;
    return f;
  endfunction

endpackage

/* design/cdsf_req_if.sv */
// ----------------------------------------------------------------------------
// cdsf_req_if
// Request channel: valid/ready with function code, position and byte.
// ----------------------------------------------------------------------------
interface cdsf_req_if;
  logic                          valid;
  logic                          ready;
  logic [cdsf_pkg::FUNC_W-1:0]   func;
  logic [cdsf_pkg::BYTE_W-1:0]   col;
  logic [cdsf_pkg::BYTE_W-1:0]   row;
  logic [cdsf_pkg::BYTE_W-1:0]   char_code;

  modport source (output valid, output func, output col, output row, output char_code,
                  input ready);
  modport sink   (input valid, input func, input col, input row, input char_code,
                  output ready);
endinterface

/* design/cdsf_rsp_if.sv */
// ----------------------------------------------------------------------------
// cdsf_rsp_if
// Frame channel: valid/ready with a 24-bit serial frame and its flags.
// ----------------------------------------------------------------------------
interface cdsf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [cdsf_pkg::FRAME_W-1:0]  frame;
  logic                          is_data;
  logic                          last;

  modport source (output valid, output frame, output is_data, output last, input ready);
  modport sink   (input valid, input frame, input is_data, input last, output ready);
endinterface

/* design/cdsf_step.sv */
// ----------------------------------------------------------------------------
// cdsf_step
// Decodes one request against the cursor and builds its frames and next cursor.
// ----------------------------------------------------------------------------
module cdsf_step #(
  parameter int MAX_COLUMNS = cdsf_pkg::MAX_COLUMNS_DEF
) (
  input  cdsf_pkg::req_t                                 req,
  input  logic [cdsf_pkg::LC_W-1:0]                      line_count,
  input  logic [cdsf_pkg::CC_W-1:0]                      column_count,
  input  logic [cdsf_pkg::col_w(MAX_COLUMNS)-1:0]        cur_col,
  input  logic [cdsf_pkg::LINE_W-1:0]                    cur_line,
  output cdsf_pkg::step_out_t                            result,
  output logic [cdsf_pkg::col_w(MAX_COLUMNS)-1:0]        next_col,
  output logic [cdsf_pkg::LINE_W-1:0]                    next_line
);
  import cdsf_pkg::*;

  localparam int CW = col_w(MAX_COLUMNS);
  localparam logic [CC_W-1:0] MAX_C = CC_W'(MAX_COLUMNS);

  logic [LC_W-1:0]   lines_eff;
  logic [CC_W-1:0]   cols_eff;
  logic              in_bounds;
  logic              cursor_out;
  logic              do_write;
  logic [CW-1:0]     wr_col;
  logic [LINE_W-1:0] wr_line;
  logic [CC_W-1:0]   col_inc;
  logic [LC_W-1:0]   line_inc;
  logic [BYTE_W-1:0] addr_byte;

  always_comb begin
    lines_eff = (line_count == '0) ? 3'd1 : (line_count > 3'd4) ? 3'd4 : line_count;
    cols_eff  = (column_count == '0) ? 6'd1 : (column_count > MAX_C) ? MAX_C : column_count;
    in_bounds = (req.col < {2'b00, cols_eff}) && (req.row < {5'b00000, lines_eff});
    cursor_out = (CC_W'(cur_col) >= cols_eff) || (LC_W'(cur_line) >= lines_eff);
  end

  always_comb begin
    result    = '0;
    next_col  = cur_col;
    next_line = cur_line;
    do_write  = 1'b0;
    wr_col    = cur_col;
    wr_line   = cur_line;

    unique case (req.func)
      FUNC_WRITE_CURSOR: begin
        do_write = 1'b1;
        // Registers may have shrunk since the cursor was placed: home first.
        if (cursor_out) begin
          wr_col  = '0;
          wr_line = '0;
        end
      end
      FUNC_WRITE_AT: begin
        if (in_bounds) begin
          do_write = 1'b1;
          wr_col   = CW'(req.col);
          wr_line  = LINE_W'(req.row);
        end
      end
      FUNC_SET_CURSOR: begin
        next_col  = in_bounds ? CW'(req.col) : '0;
        next_line = in_bounds ? LINE_W'(req.row) : '0;
      end
      FUNC_CLEAR: begin
        result.count = 2'd1;
        result.first = make_frame(CMD_CLEAR, 1'b0, 1'b1);
        next_col     = '0;
        next_line    = '0;
      end
      FUNC_RAW_CMD: begin
        result.count = 2'd1;
        result.first = make_frame(req.char_code, 1'b0, 1'b1);
      end
      FUNC_RAW_DATA: begin
        result.count = 2'd1;
        result.first = make_frame(req.char_code, 1'b1, 1'b1);
      end
      default: ;
    endcase

    addr_byte = line_base(wr_line, lines_eff) + BYTE_W'(wr_col);
    col_inc   = CC_W'(wr_col) + 6'd1;
    line_inc  = LC_W'(wr_line);
    // Advance, wrapping to the next line and then to home.
    if (col_inc >= cols_eff) begin
      col_inc  = '0;
      line_inc = line_inc + 3'd1;
    end
    if (line_inc >= lines_eff) begin
      line_inc = '0;
    end

    if (do_write) begin
      result.count  = 2'd2;
      result.first  = make_frame(addr_byte, 1'b0, 1'b0);
      result.second = make_frame(req.char_code, 1'b1, 1'b1);
      next_col      = col_inc[CW-1:0];
      next_line     = line_inc[LINE_W-1:0];
    end
  end

endmodule

/* design/char_display_serial_framer.sv */
// ----------------------------------------------------------------------------
// char_display_serial_framer
// Path: a request is held in the input stage, then its frames load the frame register.
// Throughput: one frame per cycle on the frame channel while the sink is ready; a
// character write sends two frames and every other request one frame or none.
// The two-entry frame register paces requests; they queue in one input stage.
// Reset (synchronous, rst high): cursor home, 2 lines, 16 columns, both channels empty.
// ----------------------------------------------------------------------------
module char_display_serial_framer #(
  parameter int MAX_COLUMNS = cdsf_pkg::MAX_COLUMNS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  cdsf_pkg::reg_idx_t            cfg_index,
  input  logic [cdsf_pkg::CFG_W-1:0]    cfg_data,
  cdsf_req_if.sink                      req,
  cdsf_rsp_if.source                    rsp
);
  import cdsf_pkg::*;

  localparam int CW = col_w(MAX_COLUMNS);

  logic [LC_W-1:0]   line_count;
  logic [CC_W-1:0]   column_count;

  logic              s1_valid;
  req_t              s1_req;

  logic [CW-1:0]     cur_col;
  logic [LINE_W-1:0] cur_line;
  logic [CW-1:0]     next_col;
  logic [LINE_W-1:0] next_line;

  step_out_t         step;

  logic [1:0]        pend;
  frame_t            slot0;
  frame_t            slot1;

  logic              rsp_fire;
  logic              load_ok;
  logic              s1_take;

  cdsf_step #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_step (
    .req          (s1_req),
    .line_count   (line_count),
    .column_count (column_count),
    .cur_col      (cur_col),
    .cur_line     (cur_line),
    .result       (step),
    .next_col     (next_col),
    .next_line    (next_line)
  );

  assign rsp_fire  = rsp.valid && rsp.ready;
  // Frame register is free when empty or when its last frame leaves now.
  assign load_ok   = (pend == 2'd0) || ((pend == 2'd1) && rsp.ready);
  assign s1_take   = s1_valid && load_ok;
  assign req.ready = !s1_valid || load_ok;

  assign rsp.valid   = (pend != 2'd0);
  assign rsp.frame   = slot0.frame;
  assign rsp.is_data = slot0.is_data;
  assign rsp.last    = slot0.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count   <= LINE_COUNT_RST;
      column_count <= COLUMN_COUNT_RST;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_LINE_COUNT:   line_count   <= cfg_data[LC_W-1:0];
        REG_COLUMN_COUNT: column_count <= cfg_data[CC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      cur_col  <= '0;
      cur_line <= '0;
      pend     <= 2'd0;
    end else begin
      if (req.ready) begin
        s1_valid <= req.valid;
      end
      if (s1_take) begin
        cur_col  <= next_col;
        cur_line <= next_line;
        pend     <= step.count;
      end else if (rsp_fire) begin
        pend <= pend - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      s1_req <= '{func: req.func, col: req.col, row: req.row, char_code: req.char_code};
    end
    if (s1_take) begin
      slot0 <= step.first;
      slot1 <= step.second;
    end else if (rsp_fire) begin
      // Advance the second frame to the head.
      slot0 <= slot1;
    end
  end

endmodule

/* design/cdsf_checker.sv */
// ----------------------------------------------------------------------------
// cdsf_checker
// Port-level checks on the frame channel of the character display framer.
// ----------------------------------------------------------------------------
`include "char_display_serial_framer_assert.svh"

module cdsf_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [cdsf_pkg::FRAME_W-1:0]  rsp_frame,
  input logic                          rsp_is_data,
  input logic                          rsp_last
);
  import cdsf_pkg::*;

  // Nothing may be offered straight out of reset.
  `CDSF_ASSERT_ALWAYS(a_empty_after_reset, clk, rst |=> !rsp_valid, "frame offered after reset")

  `CDSF_ASSERT(a_start_byte, clk, rst, rsp_valid |-> (rsp_frame[23:16] == (rsp_is_data ? START_DATA : START_CMD)), "start byte does not match register select")

  `CDSF_ASSERT(a_fillers, clk, rst, rsp_valid |-> ((rsp_frame[11:8] == 4'h0) && (rsp_frame[3:0] == 4'h0)), "nibble fillers not zero")

  // Only the address command of a character write is not final.
  `CDSF_ASSERT(a_pair_order, clk, rst, (rsp_valid && !rsp_last) |-> !rsp_is_data, "data frame not marked last")

  `CDSF_ASSERT(a_hold, clk, rst, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_frame) && $stable(rsp_last)), "stalled frame changed")

endmodule

bind char_display_serial_framer cdsf_checker u_cdsf_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_frame   (rsp.frame),
  .rsp_is_data (rsp.is_data),
  .rsp_last    (rsp.last)
);

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - character display serial framer testbench
// Drives display requests through bursts and gaps, predicts the serial
// frames of each accepted request from a cursor model of its own, and
// checks every frame against the oldest expected one under a stalling sink.
// Line and column counts are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;
  import cdsf_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 10;

  // Function codes the block ignores
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_LO = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_HI = 3'd7;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_EVERY_THIRD,
    STALL_HEAVY,
    STALL_BLOCKS
  } stall_mode_t;

  logic              clk;
  logic              rst;
  logic              cfg_wen;
  reg_idx_t          cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  cdsf_req_if req_ch ();
  cdsf_rsp_if rsp_ch ();

  char_display_serial_framer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // Display state as the block should hold it
  logic [LC_W-1:0]  lines_cfg;
  logic [CC_W-1:0]  cols_cfg;
  logic [4:0]       cur_col;
  logic [LINE_W-1:0] cur_line;

  req_t   requests_queued[$];
  frame_t frames_due[$];
  req_t   on_bus;
  int     burst_left;
  int     gap_left;
  int     fail_count;
  int     cycles = 0;
  int     ready_tick;
  stall_mode_t stall_mode;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int eff_lines();
    if (lines_cfg == 0) return 1;
    if (lines_cfg > 4) return 4;
    return lines_cfg;
  endfunction

  function automatic int eff_cols();
    if (cols_cfg == 0) return 1;
    if (cols_cfg > MAX_COLUMNS_DEF) return MAX_COLUMNS_DEF;
    return cols_cfg;
  endfunction

  function automatic logic [BYTE_W-1:0] line_address(logic [LINE_W-1:0] line, int lines);
    case (line)
      2'd0: return BASE_LINE0;
      2'd1: return (lines == 2) ? BASE_LINE2 : BASE_LINE1;
      2'd2: return BASE_LINE2;
      default: return BASE_LINE3;
    endcase
  endfunction

  function automatic logic [FRAME_W-1:0] serial_frame(logic [BYTE_W-1:0] b, logic data);
    logic [FRAME_W-1:0] f;
    f = {(data ? START_DATA : START_CMD), 16'h0000};
    // nibbles go out LSB first, each padded with four zeros
    for (int i = 0; i < 4; i++) begin
      f[15-i] = b[i];
      f[7-i]  = b[i+4];
    end
    return f;
  endfunction

  task automatic push_frame(logic [BYTE_W-1:0] b, logic data, logic last);
    frame_t f;
    f.frame   = serial_frame(b, data);
    f.is_data = data;
    f.last    = last;
    frames_due.push_back(f);
  endtask

  task automatic predict_char(logic [BYTE_W-1:0] ch, int lines, int cols);
    int nc;
    int nl;
    push_frame(line_address(cur_line, lines) + cur_col, 1'b0, 1'b0);
    push_frame(ch, 1'b1, 1'b1);
    nc = cur_col + 1;
    nl = cur_line;
    if (nc >= cols) begin
      nl++;
      nc = 0;
    end
    if (nl >= lines) nl = 0;
    cur_col  = nc[4:0];
    cur_line = nl[1:0];
  endtask

  task automatic predict_frames(req_t r);
    int   lines;
    int   cols;
    logic fits;
    lines = eff_lines();
    cols  = eff_cols();
    fits  = (r.col < cols) && (r.row < lines);
    case (r.func)
      FUNC_WRITE_CURSOR: begin
        // cursor left stranded by a smaller geometry: home first
        if (cur_col >= cols || cur_line >= lines) begin
          cur_col  = '0;
          cur_line = '0;
        end
        predict_char(r.char_code, lines, cols);
      end
      FUNC_WRITE_AT: begin
        if (fits) begin
          cur_col  = r.col[4:0];
          cur_line = r.row[1:0];
          predict_char(r.char_code, lines, cols);
        end
      end
      FUNC_SET_CURSOR: begin
        cur_col  = fits ? r.col[4:0] : 5'd0;
        cur_line = fits ? r.row[1:0] : 2'd0;
      end
      FUNC_CLEAR: begin
        push_frame(CMD_CLEAR, 1'b0, 1'b1);
        cur_col  = '0;
        cur_line = '0;
      end
      FUNC_RAW_CMD:  push_frame(r.char_code, 1'b0, 1'b1);
      FUNC_RAW_DATA: push_frame(r.char_code, 1'b1, 1'b1);
      default: ;
    endcase
  endtask

  task automatic queue_request(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] col,
                               logic [BYTE_W-1:0] row, logic [BYTE_W-1:0] ch);
    req_t r;
    r.func      = func;
    r.col       = col;
    r.row       = row;
    r.char_code = ch;
    requests_queued.push_back(r);
  endtask

  function automatic req_t random_request();
    req_t r;
    int   pick;
    int   lines;
    int   cols;
    lines = eff_lines();
    cols  = eff_cols();
    pick  = $urandom_range(0, 99);
    if (pick < 35)      r.func = FUNC_WRITE_CURSOR;
    else if (pick < 55) r.func = FUNC_WRITE_AT;
    else if (pick < 70) r.func = FUNC_SET_CURSOR;
    else if (pick < 75) r.func = FUNC_CLEAR;
    else if (pick < 85) r.func = FUNC_RAW_CMD;
    else if (pick < 95) r.func = FUNC_RAW_DATA;
    else r.func = ($urandom_range(0, 1) == 0) ? FUNC_UNUSED_LO : FUNC_UNUSED_HI;
    r.char_code = BYTE_W'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0, 1: begin
        r.col = BYTE_W'($urandom_range(0, 255));
        r.row = BYTE_W'($urandom_range(0, 255));
      end
      2: begin
        r.col = BYTE_W'(cols);
        r.row = BYTE_W'($urandom_range(0, lines - 1));
      end
      3: begin
        r.col = BYTE_W'($urandom_range(0, cols - 1));
        r.row = BYTE_W'(lines);
      end
      default: begin
        r.col = BYTE_W'($urandom_range(0, cols - 1));
        r.row = BYTE_W'($urandom_range(0, lines - 1));
      end
    endcase
    return r;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (requests_queued.size() != 0 || req_ch.valid || frames_due.size() != 0);
    // requests that emit nothing may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_LINE_COUNT) lines_cfg = val[LC_W-1:0];
    else cols_cfg = val[CC_W-1:0];
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] lc, logic [CFG_W-1:0] cc, int n);
    wait_idle();
    write_reg(REG_LINE_COUNT, lc);
    write_reg(REG_COLUMN_COUNT, cc);
    queue_request(FUNC_WRITE_CURSOR, 8'h00, 8'h00, BYTE_W'($urandom_range(0, 255)));
    repeat (n) requests_queued.push_back(random_request());
    // park the cursor in the far corner so the next geometry may strand it
    queue_request(FUNC_SET_CURSOR, BYTE_W'(eff_cols() - 1), BYTE_W'(eff_lines() - 1),
                  8'h00);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid     <= 1'b0;
      req_ch.func      <= '0;
      req_ch.col       <= '0;
      req_ch.row       <= '0;
      req_ch.char_code <= '0;
      burst_left = 0;
      gap_left   = 0;
      cur_col    = '0;
      cur_line   = '0;
    end else begin
      if (req_ch.valid && req_ch.ready) predict_frames(on_bus);
      if (!req_ch.valid || req_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          req_ch.valid <= 1'b0;
        end else if (requests_queued.size() != 0) begin
          on_bus = requests_queued.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.func      <= on_bus.func;
          req_ch.col       <= on_bus.col;
          req_ch.row       <= on_bus.row;
          req_ch.char_code <= on_bus.char_code;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
          end else begin
            burst_left--;
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_frame();
    frame_t want;
    if (frames_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected frame %06h is_data %b last %b",
                 rsp_ch.frame, rsp_ch.is_data, rsp_ch.last);
    end else begin
      want = frames_due.pop_front();
      if (rsp_ch.frame !== want.frame || rsp_ch.is_data !== want.is_data ||
          rsp_ch.last !== want.last) begin
        fail_count++;
        if (fail_count <= 10)
          $display("frame mismatch: expected %06h/%b/%b, got %06h/%b/%b",
                   want.frame, want.is_data, want.last,
                   rsp_ch.frame, rsp_ch.is_data, rsp_ch.last);
      end
    end
  endtask

  // Frame monitor with its own stall pattern
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      ready_tick = 0;
      stall_mode = STALL_NONE;
      fail_count = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) check_frame();
      if (ready_tick == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 4));
        ready_tick = $urandom_range(20, 80);
      end else begin
        ready_tick--;
      end
      case (stall_mode)
        STALL_NONE:        rsp_ch.ready <= 1'b1;
        STALL_LIGHT:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        STALL_EVERY_THIRD: rsp_ch.ready <= (ready_tick % 3 == 0);
        STALL_HEAVY:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        default:           rsp_ch.ready <= ready_tick[3];
      endcase
    end
  end

  always @(posedge clk) begin
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      cycles++;
    end
  end

  initial begin
    rst              = 1'b1;
    cfg_wen          = 1'b0;
    cfg_index        = REG_LINE_COUNT;
    cfg_data         = '0;
    lines_cfg        = LINE_COUNT_RST;
    cols_cfg         = COLUMN_COUNT_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset geometry of two lines by sixteen columns
    queue_request(FUNC_WRITE_CURSOR, 8'h00, 8'h00, 8'h41);
    queue_request(FUNC_WRITE_CURSOR, 8'hFF, 8'hFF, 8'h00);
    queue_request(FUNC_WRITE_CURSOR, 8'h00, 8'h00, 8'hFF);
    queue_request(FUNC_WRITE_AT, 8'd15, 8'd1, 8'h55);
    queue_request(FUNC_WRITE_AT, 8'd0, 8'd1, 8'hAA);
    queue_request(FUNC_WRITE_AT, 8'd16, 8'd0, 8'h11);
    queue_request(FUNC_WRITE_AT, 8'd0, 8'd2, 8'h22);
    queue_request(FUNC_WRITE_AT, 8'hFF, 8'hFF, 8'h33);
    queue_request(FUNC_WRITE_CURSOR, 8'h00, 8'h00, 8'h44);
    queue_request(FUNC_SET_CURSOR, 8'd15, 8'd0, 8'h00);
    queue_request(FUNC_WRITE_CURSOR, 8'h00, 8'h00, 8'h5A);
    queue_request(FUNC_SET_CURSOR, 8'hFF, 8'hFF, 8'hFF);
    queue_request(FUNC_WRITE_CURSOR, 8'h00, 8'h00, 8'hA5);
    queue_request(FUNC_SET_CURSOR, 8'd3, 8'd1, 8'h00);
    queue_request(FUNC_CLEAR, 8'hFF, 8'hFF, 8'hFF);
    queue_request(FUNC_WRITE_CURSOR, 8'h00, 8'h00, 8'h7E);
    queue_request(FUNC_RAW_CMD, 8'h00, 8'h00, 8'h00);
    queue_request(FUNC_RAW_CMD, 8'hFF, 8'hFF, 8'hFF);
    queue_request(FUNC_RAW_DATA, 8'h00, 8'h00, 8'h00);
    queue_request(FUNC_RAW_DATA, 8'hFF, 8'hFF, 8'hFF);
    queue_request(FUNC_UNUSED_LO, 8'hFF, 8'hFF, 8'hFF);
    queue_request(FUNC_UNUSED_HI, 8'h00, 8'h00, 8'h00);
    queue_request(FUNC_WRITE_CURSOR, 8'h00, 8'h00, 8'h3C);

    // Geometry sweep, extremes and out-of-range values included
    run_phase(6'd1, 6'd1, 60);
    run_phase(6'd4, 6'd32, 150);
    run_phase(6'd3, 6'd20, 100);
    run_phase(6'd0, 6'd0, 50);
    run_phase(6'd7, 6'd63, 120);
    run_phase(6'd5, 6'd40, 60);
    run_phase(6'd2, 6'd5, 100);
    run_phase(6'd1, 6'd32, 60);
    run_phase(6'd4, 6'd1, 50);
    repeat (4) run_phase(CFG_W'($urandom_range(0, 7)), CFG_W'($urandom_range(0, 63)), 25);

    wait_idle();
    if (fail_count == 0 && frames_due.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
